@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define KSC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, reset masks the check.
`define KSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ sv/ksc_pkg.sv @@
// Package: types, codes, constants and microcode ROM of the keyword substitution cipher.
`default_nettype none
package ksc_pkg;

    localparam int LETTER_COUNT = 26;
    localparam int IDX_W        = $clog2(LETTER_COUNT);

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;

    typedef enum logic [2:0] {
        REQ_BEGIN  = 3'd0,
        REQ_KEY    = 3'd1,
        REQ_FINISH = 3'd2,
        REQ_ENC    = 3'd3,
        REQ_DEC    = 3'd4
    } req_t;

    typedef enum logic [2:0] {
        STEP_FETCH,
        STEP_BEGIN,
        STEP_KEY,
        STEP_FIN_INIT,
        STEP_FIN_LOOP,
        STEP_ENC,
        STEP_DEC
    } step_t;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_IDENT,
        OP_PLACE_BYTE,
        OP_CLR_K,
        OP_PLACE_K,
        OP_MAP_FWD,
        OP_MAP_INV
    } op_t;

    typedef enum logic [1:0] {
        JMP_GOTO,
        JMP_DISPATCH,
        JMP_LOOP,
        JMP_WAIT
    } jmp_t;

    typedef struct packed {
        logic  ready;
        op_t   op;
        jmp_t  jmp;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic out_free;
        logic k_last;
    } status_t;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t cw;
        cw = '{ready: 1'b0, op: OP_NOP, jmp: JMP_GOTO, target: STEP_FETCH};
        case (s)
            STEP_FETCH: begin
                cw.ready = 1'b1;
                cw.jmp   = JMP_DISPATCH;
            end
            STEP_BEGIN:    cw.op = OP_IDENT;
            STEP_KEY:      cw.op = OP_PLACE_BYTE;
            STEP_FIN_INIT: begin
                cw.op     = OP_CLR_K;
                cw.target = STEP_FIN_LOOP;
            end
            STEP_FIN_LOOP: begin
                cw.op  = OP_PLACE_K;
                cw.jmp = JMP_LOOP;
            end
            STEP_ENC: begin
                cw.op  = OP_MAP_FWD;
                cw.jmp = JMP_WAIT;
            end
            STEP_DEC: begin
                cw.op  = OP_MAP_INV;
                cw.jmp = JMP_WAIT;
            end
            default: cw.target = STEP_FETCH;
        endcase
        return cw;
    endfunction

    function automatic step_t dispatch(input logic [2:0] req);
        step_t s;
        case (req)
            REQ_BEGIN:  s = STEP_BEGIN;
            REQ_KEY:    s = STEP_KEY;
            REQ_FINISH: s = STEP_FIN_INIT;
            REQ_ENC:    s = STEP_ENC;
            REQ_DEC:    s = STEP_DEC;
            default:    s = STEP_FETCH;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

@@ sv/ksc_seq.sv @@
// Microcode sequencer: step register, control ROM and jump logic.
`default_nettype none
module ksc_seq
    import ksc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_valid,
    input  wire logic [2:0] in_req,
    input  wire status_t    status,
    output logic            accept,
    output ctrl_t           ctrl
);

    step_t step_reg, step_next;
    ctrl_t rom_word;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        rom_word  = ucode(step_reg);
        accept    = rom_word.ready && in_valid;
        ctrl      = rom_word;
        step_next = step_reg;
        case (rom_word.jmp)
            JMP_GOTO:     step_next = rom_word.target;
            JMP_DISPATCH: if (accept) step_next = dispatch(in_req);
            JMP_LOOP:     if (status.k_last) step_next = rom_word.target;
            JMP_WAIT: begin
                if (status.out_free) begin
                    step_next = rom_word.target;
                end else begin
                    ctrl.op = OP_NOP;
                end
            end
            default:      step_next = STEP_FETCH;
        endcase
    end

endmodule
`default_nettype wire

@@ sv/ksc_dp.sv @@
// Datapath: cipher tables, used marks, fill pointer, letter counter and output register.
`default_nettype none
module ksc_dp
    import ksc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ctrl_t      ctrl,
    input  wire logic       accept,
    input  wire logic [7:0] in_byte,
    input  wire logic       out_ready,
    output status_t         status,
    output logic            out_valid,
    output logic [7:0]      out_byte
);

    logic [IDX_W-1:0]        fwd_reg [0:LETTER_COUNT-1];
    logic [IDX_W-1:0]        inv_reg [0:LETTER_COUNT-1];
    logic [LETTER_COUNT-1:0] used_reg;
    logic [IDX_W-1:0]        fill_reg;
    logic [IDX_W-1:0]        k_reg;
    logic [7:0]              byte_reg;
    logic                    out_valid_reg;
    logic [7:0]              out_data_reg;

    logic             is_upper, is_lower, is_letter;
    logic [7:0]       diff;
    logic [IDX_W-1:0] letter_idx, place_idx, map_val;
    logic             place_en;
    logic [7:0]       map_byte;

    always_comb begin
        is_upper   = byte_reg inside {[CH_UPPER_A:CH_UPPER_Z]};
        is_lower   = byte_reg inside {[CH_LOWER_A:CH_LOWER_Z]};
        is_letter  = is_upper || is_lower;
        diff       = byte_reg - (is_upper ? CH_UPPER_A : CH_LOWER_A);
        letter_idx = diff[IDX_W-1:0];

        place_idx = (ctrl.op == OP_PLACE_K) ? k_reg : letter_idx;
        place_en  = ((ctrl.op == OP_PLACE_K) || ((ctrl.op == OP_PLACE_BYTE) && is_letter))
                    && !used_reg[place_idx] && (fill_reg < IDX_W'(LETTER_COUNT));

        map_val = '0;
        if (is_letter) begin
            map_val = (ctrl.op == OP_MAP_INV) ? inv_reg[letter_idx] : fwd_reg[letter_idx];
        end
        if (is_upper) begin
            map_byte = CH_UPPER_A + {{(8-IDX_W){1'b0}}, map_val};
        end else if (is_lower) begin
            map_byte = CH_LOWER_A + {{(8-IDX_W){1'b0}}, map_val};
        end else begin
            map_byte = byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.op == OP_IDENT) begin
            for (int i = 0; i < LETTER_COUNT; i++) begin
                fwd_reg[i] <= IDX_W'(i);
                inv_reg[i] <= IDX_W'(i);
            end
            used_reg <= '0;
            fill_reg <= '0;
        end else if (place_en) begin
            fwd_reg[fill_reg]  <= place_idx;
            inv_reg[place_idx] <= fill_reg;
            used_reg[place_idx] <= 1'b1;
            fill_reg <= fill_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ctrl.op == OP_CLR_K) begin
                k_reg <= '0;
            end else if (ctrl.op == OP_PLACE_K) begin
                k_reg <= k_reg + 1'b1;
            end
            if (ctrl.op == OP_MAP_FWD || ctrl.op == OP_MAP_INV) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            byte_reg <= in_byte;
        end
        if (ctrl.op == OP_MAP_FWD || ctrl.op == OP_MAP_INV) begin
            out_data_reg <= map_byte;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.k_last   = (k_reg == IDX_W'(LETTER_COUNT - 1));
    assign out_valid       = out_valid_reg;
    assign out_byte        = out_data_reg;

endmodule
`default_nettype wire

@@ sv/keyword_substitution_cipher_top.sv @@
// Top level of the keyword substitution cipher.
// Input stream: s_tuser carries the request kind (begin, keyword byte, finish,
// encrypt, decrypt), s_tdata the byte. Output stream: m_tdata carries the
// encrypted or decrypted byte; only encrypt and decrypt produce a transaction.
// A small control ROM steps the datapath: a fetch step takes one input
// transaction, then a short routine runs for it.
// Encrypt/decrypt: the accepted byte is registered, then its lookup step
// writes the result to the output register on m_tdata once that register is
// free; no new input is taken before that. Finish walks the 26 letters
// one per cycle through the shared placement logic.
// Reset (aresetn low, synchronous): both tables return to the identity
// alphabet, used marks and fill pointer clear, output empties.
// Receiver stall: the result holds in the output register; a new input is
// still taken, and its lookup step waits until the register drains.
`default_nettype none
module keyword_substitution_cipher_top
    import ksc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic [2:0] s_tuser,   // [2:0] req_type
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata    // [7:0] out_byte
);

    ctrl_t   ctrl;
    status_t status;
    logic    accept;

    ksc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_req   (s_tuser),
        .status   (status),
        .accept   (accept),
        .ctrl     (ctrl)
    );

    ksc_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (ctrl),
        .accept    (accept),
        .in_byte   (s_tdata),
        .out_ready (m_tready),
        .status    (status),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata)
    );

    assign s_tready = ctrl.ready;

endmodule
`default_nettype wire

@@ sv/ksc_checker.sv @@
// Port-level checker for the keyword substitution cipher, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module ksc_checker
    import ksc_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic [7:0] s_tdata,
    input wire logic [2:0] s_tuser,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata
);

    logic text_acc, non_letter;

    assign text_acc = s_tvalid && s_tready && !m_tvalid
                      && (s_tuser == REQ_ENC || s_tuser == REQ_DEC);
    assign non_letter = !((s_tdata >= CH_UPPER_A && s_tdata <= CH_UPPER_Z)
                          || (s_tdata >= CH_LOWER_A && s_tdata <= CH_LOWER_Z));

    `KSC_ASSERT_NEXT(a_out_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `KSC_ASSERT_NEXT(a_out_hold_data, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `KSC_ASSERT_SAME(a_text_latency, aclk, aresetn, text_acc, ##2 m_tvalid)
    `KSC_ASSERT_SAME(a_pass_through, aclk, aresetn, text_acc && non_letter, ##2 (m_tdata == $past(s_tdata, 2)))

endmodule

bind keyword_substitution_cipher_top ksc_checker u_ksc_checker (.*);
`default_nettype wire
